@@ rtl/greedy_word_wrap_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Greedy word wrap assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_WORD_WRAP_UNIT_DEFINES_SVH
`define GREEDY_WORD_WRAP_UNIT_DEFINES_SVH

// same-cycle implication
`define GWW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GWW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gww_pkg.sv @@
// ----------------------------------------------------------------------------
// Greedy word wrap package
// Widths, character codes, command and port types shared by the wrap unit.
// ----------------------------------------------------------------------------
package gww_pkg;

  localparam int WORD_MAX  = 32;
  localparam int LEN_W     = $clog2(WORD_MAX + 1);
  localparam int IDX_W     = $clog2(WORD_MAX);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int BYTE_W    = 8;
  localparam int COL_W     = 8;
  localparam int RUN_W     = 2;
  localparam int TAIL_W    = 2;
  localparam int CMD_DEPTH = 2;

  localparam logic [COL_W-1:0]  LINE_WIDTH_RST = 8'd80;
  localparam logic [BYTE_W-1:0] CH_SPACE       = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NEWLINE     = 8'h0A;

  typedef enum logic [1:0] {
    SEP_NONE,
    SEP_SPACE,
    SEP_NEWLINE
  } sep_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEP,
    BK_FETCH,
    BK_CHAR,
    BK_TAIL
  } back_state_e;

  typedef struct packed {
    sep_e              sep;
    logic [LEN_W-1:0]  len;
    logic              bank;
    logic [TAIL_W-1:0] tail;
    logic              err;
  } wrap_cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } word_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

endpackage

@@ rtl/gww_front.sv @@
// ----------------------------------------------------------------------------
// Greedy word wrap front end
// Accepts bytes, buffers words, places each word and queues emit commands.
// ----------------------------------------------------------------------------
`include "greedy_word_wrap_unit_defines.svh"

module gww_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [gww_pkg::BYTE_W-1:0]     data_byte_i,
  input  logic                           end_of_input_i,
  input  logic                           cfg_valid_i,
  input  logic [gww_pkg::COL_W-1:0]      cfg_line_width_i,
  input  logic                           fifo_full_i,
  output logic                           push_o,
  output gww_pkg::wrap_cmd_t             cmd_o,
  output gww_pkg::word_wr_t              wr_o,
  input  gww_pkg::bank_rel_t             rel_i
);
  import gww_pkg::*;

  logic [COL_W-1:0]  width_q;
  logic [LEN_W-1:0]  word_len_q, word_len_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [RUN_W-1:0]  run_q, run_d;
  logic              error_q, error_d;
  logic              bank_q, bank_d;
  logic [1:0]        busy_q, busy_d;

  logic              accept;
  logic              is_nl;
  logic              is_sp;
  logic              is_chr;
  logic              flush;
  logic              has_word;
  logic              buf_full;
  logic [COL_W:0]    fit_sum;
  logic              fits;
  logic              too_long;
  sep_e              sep;
  logic [COL_W-1:0]  col_f;
  logic [TAIL_W-1:0] tail;

  assign in_ready_o = !fifo_full_i && !busy_q[bank_q];

  always_comb begin
    accept   = in_valid_i && in_ready_o;
    is_nl    = !end_of_input_i && (data_byte_i == CH_NEWLINE);
    is_sp    = !end_of_input_i && (data_byte_i == CH_SPACE);
    is_chr   = !end_of_input_i && !is_nl && !is_sp;
    flush    = accept && !is_chr;
    has_word = (word_len_q != '0);
    buf_full = (word_len_q >= LEN_W'(WORD_MAX));
    fit_sum  = {1'b0, col_q} + (COL_W + 1)'(word_len_q) + (COL_W + 1)'(1);
    fits     = (fit_sum <= {1'b0, width_q});
    too_long = has_word && (COL_W'(word_len_q) > width_q);

    sep   = SEP_NONE;
    col_f = col_q;
    if (has_word) begin
      if (col_q == '0) begin
        col_f = COL_W'(word_len_q);
      end else if (fits) begin
        sep   = SEP_SPACE;
        col_f = fit_sum[COL_W-1:0];
      end else begin
        sep   = SEP_NEWLINE;
        col_f = COL_W'(word_len_q);
      end
    end

    tail       = '0;
    word_len_d = word_len_q;
    col_d      = col_q;
    run_d      = run_q;
    error_d    = error_q;
    if (accept) begin
      priority if (end_of_input_i) begin
        tail  = TAIL_W'(1);
        col_d = '0;
        run_d = '0;
      end else if (is_nl) begin
        if (run_q == RUN_W'(1)) begin
          tail  = TAIL_W'(2);
          col_d = '0;
        end else begin
          col_d = col_f;
        end
        run_d = (run_q == RUN_W'(2)) ? run_q : run_q + RUN_W'(1);
      end else if (is_sp) begin
        col_d = col_f;
        run_d = '0;
      end else begin
        run_d = '0;
        if (buf_full) begin
          error_d = 1'b1;
        end else begin
          word_len_d = word_len_q + LEN_W'(1);
        end
      end
      if (flush) begin
        word_len_d = '0;
        error_d    = error_q | too_long;
      end
    end

    push_o      = flush && (has_word || (tail != '0));
    cmd_o.sep   = sep;
    cmd_o.len   = word_len_q;
    cmd_o.bank  = bank_q;
    cmd_o.tail  = tail;
    cmd_o.err   = error_q | too_long;

    wr_o.en     = accept && is_chr && !buf_full;
    wr_o.addr   = {bank_q, word_len_q[IDX_W-1:0]};
    wr_o.data   = data_byte_i;

    bank_d = bank_q;
    busy_d = busy_q;
    if (rel_i.en) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (flush && has_word) begin
      bank_d         = ~bank_q;
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= LINE_WIDTH_RST;
      word_len_q <= '0;
      col_q      <= '0;
      run_q      <= '0;
      error_q    <= 1'b0;
      bank_q     <= 1'b0;
      busy_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        width_q <= cfg_line_width_i;
      end
      word_len_q <= word_len_d;
      col_q      <= col_d;
      run_q      <= run_d;
      error_q    <= error_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
    end
  end

  `GWW_ASSERT_IMPL(a_push_has_room, push_o, !fifo_full_i, "command pushed into full queue")
  `GWW_ASSERT_IMPL(a_write_free_bank, wr_o.en, !busy_q[bank_q], "write into bank being drained")
  `GWW_ASSERT_NEXT(a_error_sticky, error_q, error_q, "error flag cleared")

endmodule

@@ rtl/gww_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// Greedy word wrap command queue
// Short queue of emit commands between the front end and the back end.
// ----------------------------------------------------------------------------
module gww_cmd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  gww_pkg::wrap_cmd_t cmd_i,
  input  logic               pop_i,
  output gww_pkg::wrap_cmd_t cmd_o,
  output logic               full_o,
  output logic               empty_o
);
  import gww_pkg::*;

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  wrap_cmd_t          entry_q [CMD_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == CNT_W'(CMD_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ rtl/gww_back.sv @@
// ----------------------------------------------------------------------------
// Greedy word wrap back end
// Holds the word banks and emits separator, word and newline bytes.
// ----------------------------------------------------------------------------
`include "greedy_word_wrap_unit_defines.svh"

module gww_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  gww_pkg::wrap_cmd_t         cmd_i,
  output logic                       pop_o,
  input  gww_pkg::word_wr_t          wr_i,
  output gww_pkg::bank_rel_t         rel_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [gww_pkg::BYTE_W-1:0] out_byte_o,
  output logic                       last_o,
  output logic                       word_too_long_o
);
  import gww_pkg::*;

  logic [BYTE_W-1:0] mem [2 * WORD_MAX];
  logic [BYTE_W-1:0] rd_data_q;

  back_state_e       state_q, state_d;
  wrap_cmd_t         cur_q, cur_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [TAIL_W-1:0] tail_cnt_q, tail_cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q;
  logic              last_q;
  logic              err_q;

  logic              out_free;
  logic              last_chr;
  logic              load;
  logic [BYTE_W-1:0] byte_n;
  logic              last_n;

  assign out_free = !out_valid_q || out_ready_i;
  assign last_chr = ({1'b0, idx_q} == (cur_q.len - LEN_W'(1)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          if (cmd_i.sep != SEP_NONE) begin
            state_d = BK_SEP;
          end else if (cmd_i.len != '0) begin
            state_d = BK_FETCH;
          end else begin
            state_d = BK_TAIL;
          end
        end
      end
      BK_SEP: begin
        if (out_free) begin
          state_d = BK_FETCH;
        end
      end
      BK_FETCH: state_d = BK_CHAR;
      BK_CHAR: begin
        if (out_free) begin
          if (!last_chr) begin
            state_d = BK_FETCH;
          end else if (cur_q.tail != '0) begin
            state_d = BK_TAIL;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      BK_TAIL: begin
        if (out_free && (tail_cnt_q == TAIL_W'(1))) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o      = 1'b0;
    load       = 1'b0;
    byte_n     = CH_NEWLINE;
    last_n     = 1'b0;
    rel_o.en   = 1'b0;
    rel_o.bank = cur_q.bank;
    cur_d      = cur_q;
    idx_d      = idx_q;
    tail_cnt_d = tail_cnt_q;
    unique case (state_q)
      BK_IDLE: begin
        pop_o      = !empty_i;
        cur_d      = cmd_i;
        idx_d      = '0;
        tail_cnt_d = cmd_i.tail;
      end
      BK_SEP: begin
        load   = out_free;
        byte_n = (cur_q.sep == SEP_SPACE) ? CH_SPACE : CH_NEWLINE;
      end
      BK_FETCH: ;
      BK_CHAR: begin
        load   = out_free;
        byte_n = rd_data_q;
        last_n = last_chr && (cur_q.tail == '0);
        if (out_free) begin
          idx_d    = idx_q + IDX_W'(1);
          rel_o.en = last_chr;
        end
      end
      BK_TAIL: begin
        load   = out_free;
        last_n = (tail_cnt_q == TAIL_W'(1));
        if (out_free) begin
          tail_cnt_d = tail_cnt_q - TAIL_W'(1);
        end
      end
      default: ;
    endcase
    out_valid_d = load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[{cur_q.bank, idx_q}];
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    idx_q      <= idx_d;
    tail_cnt_q <= tail_cnt_d;
    if (load) begin
      out_byte_q <= byte_n;
      last_q     <= last_n;
      err_q      <= cur_q.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign last_o          = last_q;
  assign word_too_long_o = err_q;

  `GWW_ASSERT_IMPL(a_pop_not_empty, pop_o, !empty_i, "pop from empty queue")
  `GWW_ASSERT_IMPL(a_char_has_word, state_q == BK_CHAR, cur_q.len != '0, "emit from empty word")
  `GWW_ASSERT_IMPL(a_tail_count, state_q == BK_TAIL, tail_cnt_q != '0, "newline run exhausted")

endmodule

@@ rtl/greedy_word_wrap_unit.sv @@
// ----------------------------------------------------------------------------
// Greedy word wrap unit
// Reflows a byte stream greedily to a configurable line width.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one byte, or an end-of-input mark, on in_valid_i /
//   in_ready_o. Output requests carry one wrapped byte each on out_valid_o /
//   out_ready_i; last_o marks the final byte caused by an input request and
//   word_too_long_o is the sticky error flag. The cfg channel writes the line
//   width and is always ready; write it only while the unit is idle.
//   With the back end idle, an accepted input request is queued as a
//   command and popped in the idle state; its first byte is loaded from
//   the separator or tail state, or after a bank read when a word opens
//   the line. Each word character takes a bank read and an output load,
//   separators and newlines only a load; commands pop only when idle.
//   Input bytes are taken one per cycle while the 2-entry command queue has
//   room and the word bank being filled is not still draining.
//   Reset clears the line state and the error flag and sets the width to 80.
//   A stalled receiver holds the output register; the queue then fills and
//   in_ready_o drops.
// ----------------------------------------------------------------------------
module greedy_word_wrap_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [gww_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       end_of_input_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [gww_pkg::COL_W-1:0]  cfg_line_width_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [gww_pkg::BYTE_W-1:0] out_byte_o,
  output logic                       last_o,
  output logic                       word_too_long_o
);
  import gww_pkg::*;

  logic      push;
  logic      pop;
  logic      full;
  logic      empty;
  wrap_cmd_t cmd_in;
  wrap_cmd_t cmd_out;
  word_wr_t  wr;
  bank_rel_t rel;

  assign cfg_ready_o = 1'b1;

  gww_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_input_i   (end_of_input_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_line_width_i (cfg_line_width_i),
    .fifo_full_i      (full),
    .push_o           (push),
    .cmd_o            (cmd_in),
    .wr_o             (wr),
    .rel_i            (rel)
  );

  gww_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .full_o  (full),
    .empty_o (empty)
  );

  gww_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .cmd_i           (cmd_out),
    .pop_o           (pop),
    .wr_i            (wr),
    .rel_o           (rel),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .last_o          (last_o),
    .word_too_long_o (word_too_long_o)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy word wrap unit testbench
// Streams directed and random text through the unit under several line
// widths and handshake idling mixes. A behavioral wrap predictor builds the
// expected output bytes for every accepted request. The monitor checks each
// output byte, last mark and error flag against them in order.
// ----------------------------------------------------------------------------
module tb;

  import gww_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eoi;
  } text_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
    logic              err;
  } wrap_out_t;

  logic              clk_i;
  logic              rst_ni         = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready_o;
  logic [BYTE_W-1:0] data_byte      = '0;
  logic              end_of_input   = 1'b0;
  logic              cfg_valid      = 1'b0;
  logic              cfg_ready_o;
  logic [COL_W-1:0]  cfg_line_width = LINE_WIDTH_RST;
  logic              out_valid_o;
  logic              out_ready      = 1'b0;
  logic [BYTE_W-1:0] out_byte_o;
  logic              last_o;
  logic              word_too_long_o;

  text_req_t         text_q[$];
  wrap_out_t         wrap_expect_q[$];
  logic [BYTE_W-1:0] step_bytes[$];
  text_req_t         nxt_req;
  wrap_out_t         want;

  logic [BYTE_W-1:0] word_buf[WORD_MAX];
  int                word_len   = 0;
  int                line_col   = 0;
  int                nl_run     = 0;
  logic              err_flag   = 1'b0;
  int                wrap_width = int'(LINE_WIDTH_RST);

  int   send_idle_pct = 27;
  int   recv_idle_pct = 86;
  bit   stall_armed   = 1'b0;
  bit   stall_done    = 1'b0;
  int   hold_left     = 0;
  int   mismatch_cnt  = 0;
  int   idle_cycles   = 0;

  greedy_word_wrap_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte),
    .end_of_input_i   (end_of_input),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_line_width_i (cfg_line_width),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .word_too_long_o  (word_too_long_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function void place_word();
    int i;
    if (word_len == 0) return;
    if (word_len > wrap_width) err_flag = 1'b1;
    if (line_col == 0) begin
      line_col = word_len;
    end else if (line_col + 1 + word_len <= wrap_width) begin
      step_bytes.push_back(CH_SPACE);
      line_col = line_col + 1 + word_len;
    end else begin
      step_bytes.push_back(CH_NEWLINE);
      line_col = word_len;
    end
    line_col = line_col & 255;
    for (i = 0; i < word_len; i++) step_bytes.push_back(word_buf[i]);
    word_len = 0;
  endfunction

  function void wrap_predict(input logic [BYTE_W-1:0] b, input logic eoi);
    int k;
    step_bytes.delete();
    if (eoi) begin
      place_word();
      step_bytes.push_back(CH_NEWLINE);
      line_col = 0;
      nl_run   = 0;
    end else if (b == CH_NEWLINE) begin
      place_word();
      if (nl_run == 1) begin
        step_bytes.push_back(CH_NEWLINE);
        step_bytes.push_back(CH_NEWLINE);
        line_col = 0;
      end
      if (nl_run < 2) nl_run++;
    end else if (b == CH_SPACE) begin
      place_word();
      nl_run = 0;
    end else begin
      nl_run = 0;
      if (word_len < WORD_MAX) begin
        word_buf[word_len] = b;
        word_len++;
      end else begin
        err_flag = 1'b1;
      end
    end
    for (k = 0; k < step_bytes.size(); k++)
      wrap_expect_q.push_back('{step_bytes[k], k == step_bytes.size() - 1, err_flag});
  endfunction

  task automatic add_byte(input logic [BYTE_W-1:0] b);
    text_q.push_back('{b, 1'b0});
  endtask

  task automatic add_str(input string s);
    foreach (s[i]) add_byte(s[i]);
  endtask

  task automatic add_eoi();
    text_q.push_back('{BYTE_W'($urandom_range(255)), 1'b1});
  endtask

  function automatic logic [BYTE_W-1:0] word_char();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(255)); while (b == CH_SPACE || b == CH_NEWLINE);
    return b;
  endfunction

  task automatic gen_text(input int n);
    int made;
    int len;
    int sel;
    int k;
    made = 0;
    while (made < n) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        add_byte(BYTE_W'($urandom_range(255)));
        made++;
      end else if (sel < 12) begin
        add_eoi();
        made++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10);
        for (k = 0; k < len; k++) add_byte(word_char());
        made += len;
        sel = $urandom_range(9);
        if (sel < 6) begin
          add_byte(CH_SPACE);
          made++;
        end else if (sel < 8) begin
          add_byte(CH_NEWLINE);
          made++;
        end else if (sel == 8) begin
          add_byte(CH_NEWLINE);
          add_byte(CH_NEWLINE);
          made += 2;
        end else begin
          add_byte(CH_NEWLINE);
          add_byte(CH_NEWLINE);
          add_byte(CH_NEWLINE);
          add_byte(CH_SPACE);
          add_byte(CH_SPACE);
          made += 5;
        end
      end
    end
    add_eoi();
  endtask

  task automatic set_width(input int w);
    @(posedge clk_i);
    cfg_valid      <= 1'b1;
    cfg_line_width <= COL_W'(w);
    do @(posedge clk_i); while (!cfg_ready_o);
    wrap_width = w;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (text_q.size() != 0 || in_valid || wrap_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid     <= 1'b0;
      data_byte    <= '0;
      end_of_input <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) wrap_predict(data_byte, end_of_input);
      if (!in_valid || in_ready_o) begin
        if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_req = text_q.pop_front();
          in_valid     <= 1'b1;
          data_byte    <= nxt_req.data;
          end_of_input <= nxt_req.eoi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (wrap_expect_q.size() == 0) begin
          $display("%0t: unexpected output byte %h", $time, out_byte_o);
          mismatch_cnt++;
        end else begin
          want = wrap_expect_q.pop_front();
          if (out_byte_o !== want.ch) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.ch, out_byte_o);
            mismatch_cnt++;
          end
          if (last_o !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, last_o);
            mismatch_cnt++;
          end
          if (word_too_long_o !== want.err) begin
            $display("%0t: word_too_long expected %b actual %b", $time, want.err,
                     word_too_long_o);
            mismatch_cnt++;
          end
        end
      end
      if (stall_armed && !stall_done && text_q.size() != 0) begin
        hold_left  = LONG_HOLD;
        stall_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready))
        idle_cycles = 0;
      else if (text_q.size() != 0 || in_valid || wrap_expect_q.size() != 0)
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // default width: words, extreme bytes, paragraph break, empty words
    add_str("ab ");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_str("\n\n\n  ");
    add_byte(8'h80);
    add_byte(8'h7F);
    add_byte(8'h01);
    add_eoi();
    wait_drained();

    // narrow line: overlong words, wrap and fit
    set_width(3);
    add_str("abcd ef g\nh");
    add_eoi();
    gen_text(12);
    wait_drained();

    set_width(0);
    gen_text(18);
    wait_drained();

    send_idle_pct = 86;
    recv_idle_pct = 27;
    set_width(255);
    gen_text(42);
    wait_drained();

    set_width(1);
    gen_text(18);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_width(12);
    stall_armed = 1'b1;
    gen_text(50);
    wait_drained();

    set_width(40);
    gen_text(45);
    wait_drained();

    if (mismatch_cnt == 0 && wrap_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
